@@ src/bmp_to_rgba_decoder_top_assert.svh @@
// Assertion macros for the BMP to RGBA decoder.
`ifndef BMP_TO_RGBA_DECODER_TOP_ASSERT_SVH
`define BMP_TO_RGBA_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BMPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bmprgba_pkg.sv @@
`default_nettype none

package bmprgba_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [PosW-1:0] PosMarkB  = 17'd0;
  localparam logic [PosW-1:0] PosMarkM  = 17'd1;
  localparam logic [PosW-1:0] PosOffLo  = 17'd10;
  localparam logic [PosW-1:0] PosOffHi  = 17'd11;
  localparam logic [PosW-1:0] PosWidLo  = 17'd18;
  localparam logic [PosW-1:0] PosWidHi  = 17'd19;
  localparam logic [PosW-1:0] PosHgtLo  = 17'd22;
  localparam logic [PosW-1:0] PosHgtHi  = 17'd23;
  localparam logic [PosW-1:0] PosDepth  = 17'd28;
  localparam logic [PosW-1:0] PosHdrEnd = 17'd53;

  localparam logic [15:0] HdrLen16    = 16'd54;
  localparam logic [31:0] HdrLen32    = 32'd54;
  localparam logic [7:0]  MarkB       = 8'h42;
  localparam logic [7:0]  MarkM       = 8'h4D;
  localparam logic [7:0]  Depth24     = 8'd24;
  localparam logic [7:0]  Depth32     = 8'd32;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  typedef enum logic [2:0] {
    StOk             = 3'd0,
    StShort          = 3'd1,
    StNoMarker       = 3'd2,
    StBadDepth       = 3'd3,
    StTruncated      = 3'd4,
    StOffsetInHeader = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PhHeader,
    PhGap,
    PhPixel,
    PhDone
  } phase_e;

  typedef enum logic {
    KindStatus = 1'b0,
    KindPixel  = 1'b1
  } kind_e;

endpackage

`default_nettype wire

@@ src/bmp_to_rgba_decoder_top.sv @@
// BMP to RGBA decoder, 24-bit and 32-bit uncompressed files.
// Config: write the file byte count on cfg_wdata_i with cfg_we_i high while
//   the block is idle, before streaming the file.
// Input channel (in_valid_i/in_ready_o): one file byte per request;
//   first_byte_i marks byte zero and restarts decoding.
// Output channel (out_valid_o/out_ready_i): one status result when header
//   byte 53 arrives, then one RGBA pixel result per complete pixel, rows
//   numbered from the top, row padding dropped.
// Each result is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle. Each byte is handled by short logic
//   between the state registers and one output register. Bytes that make no
//   result are taken even while the output is stalled; a byte that makes a
//   result waits only while the output register holds an untaken result.
// Size checks (stride, stride*height, plus pixel offset) run in a small
//   free-running register chain fed by the captured header fields; it settles
//   long before byte 53 arrives.
// Reset: all decode state clears; the first byte after reset counts as byte
//   zero. The byte count register resets to zero.
`default_nettype none

module bmp_to_rgba_decoder_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [31:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     first_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     kind_o,
  output logic [2:0]               status_o,
  output logic [15:0]              image_width_o,
  output logic [15:0]              image_height_o,
  output logic [15:0]              pixel_x_o,
  output logic [15:0]              pixel_y_o,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic [7:0]               alpha_o,
  output logic                     last_pixel_o
);
  import bmprgba_pkg::*;

  `include "bmp_to_rgba_decoder_top_assert.svh"

  // Config register
  logic [31:0] file_length_q;

  // Decode state
  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [15:0]     data_start_q, data_start_d;
  logic [15:0]     width_q, width_d;
  logic [15:0]     height_q, height_d;
  logic [7:0]      depth_q, depth_d;
  logic            marker_q, marker_d;
  logic [17:0]     lbc_q, lbc_d;
  logic [1:0]      ch_q, ch_d;
  logic [15:0]     col_q, col_d;
  logic [15:0]     row_q, row_d;
  logic [23:0]     hold_q, hold_d;

  // Size-check chain
  logic        four_ch;
  logic [17:0] active_q;
  logic [17:0] stride_q;
  logic [33:0] prod_q;
  logic [34:0] need_q;

  // Output register
  logic        out_valid_q;
  kind_e       kind_q;
  status_e     status_q;
  logic [15:0] img_w_q, img_h_q, pix_x_q, pix_y_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        last_q;

  // Per-byte combinational view
  logic [PosW-1:0] cur_pos;
  phase_e          cur_phase;
  logic            hdr_emit, pix_phase, in_active, last_ch, pix_emit, emit;
  logic            in_fire;
  status_e         hdr_status;
  logic [18:0]     lbc_inc;
  logic [16:0]     row_inc, col_inc;

  // Result fields
  kind_e       res_kind;
  status_e     res_status;
  logic [15:0] res_x, res_y;
  logic [7:0]  res_red, res_green, res_blue, res_alpha;
  logic        res_last;

  assign four_ch = (depth_q == Depth32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (cfg_we_i) begin
      file_length_q <= cfg_wdata_i;
    end
  end

  // Free-running size chain; inputs are stable well before byte 53.
  always_ff @(posedge clk_i) begin
    active_q <= four_ch ? {width_q, 2'b00} : ({1'b0, width_q, 1'b0} + {2'b00, width_q});
    stride_q <= (active_q + 18'd3) & ~18'd3;
    prod_q   <= stride_q * height_q;
    need_q   <= {1'b0, prod_q} + {19'd0, data_start_q};
  end

  // Effective state for this byte (first_byte restarts at byte zero)
  assign cur_pos   = first_byte_i ? '0 : pos_q;
  assign cur_phase = first_byte_i ? PhHeader : phase_q;

  assign hdr_emit  = (cur_phase == PhHeader) && (cur_pos == PosHdrEnd);
  assign pix_phase = (cur_phase == PhPixel) ||
                     ((cur_phase == PhGap) && (cur_pos >= {1'b0, data_start_q}));
  assign in_active = (lbc_q < active_q);
  assign last_ch   = four_ch ? (ch_q == 2'd3) : (ch_q == 2'd2);
  assign pix_emit  = pix_phase && in_active && last_ch;
  assign emit      = hdr_emit || pix_emit;

  assign in_ready_o = !out_valid_q || out_ready_i || !emit;
  assign in_fire    = in_valid_i && in_ready_o;

  assign lbc_inc = {1'b0, lbc_q} + 19'd1;
  assign row_inc = {1'b0, row_q} + 17'd1;
  assign col_inc = {1'b0, col_q} + 17'd1;

  // Header status, checks in priority order
  always_comb begin
    priority if (file_length_q < HdrLen32) begin
      hdr_status = StShort;
    end else if (!marker_q) begin
      hdr_status = StNoMarker;
    end else if ((depth_q != Depth24) && (depth_q != Depth32)) begin
      hdr_status = StBadDepth;
    end else if ({3'b000, file_length_q} < need_q) begin
      hdr_status = StTruncated;
    end else if (data_start_q < HdrLen16) begin
      hdr_status = StOffsetInHeader;
    end else begin
      hdr_status = StOk;
    end
  end

  // Next state
  always_comb begin
    pos_d        = (cur_pos == '1) ? cur_pos : cur_pos + 1'b1;
    phase_d      = cur_phase;
    data_start_d = first_byte_i ? '0 : data_start_q;
    width_d      = first_byte_i ? '0 : width_q;
    height_d     = first_byte_i ? '0 : height_q;
    depth_d      = first_byte_i ? '0 : depth_q;
    marker_d     = first_byte_i ? 1'b0 : marker_q;
    lbc_d        = lbc_q;
    ch_d         = ch_q;
    col_d        = col_q;
    row_d        = row_q;
    hold_d       = hold_q;

    unique case (cur_phase)
      PhHeader: begin
        if (cur_pos == PosMarkB) marker_d = (data_byte_i == MarkB);
        if (cur_pos == PosMarkM) marker_d = marker_q && (data_byte_i == MarkM);
        if (cur_pos == PosOffLo) data_start_d[7:0]  = data_byte_i;
        if (cur_pos == PosOffHi) data_start_d[15:8] = data_byte_i;
        if (cur_pos == PosWidLo) width_d[7:0]       = data_byte_i;
        if (cur_pos == PosWidHi) width_d[15:8]      = data_byte_i;
        if (cur_pos == PosHgtLo) height_d[7:0]      = data_byte_i;
        if (cur_pos == PosHgtHi) height_d[15:8]     = data_byte_i;
        if (cur_pos == PosDepth) depth_d            = data_byte_i;
        if (hdr_emit) begin
          // pixel walk starts clean
          lbc_d  = '0;
          ch_d   = '0;
          col_d  = '0;
          row_d  = '0;
          hold_d = '0;
          if ((hdr_status != StOk) || (width_q == '0) || (height_q == '0)) begin
            phase_d = PhDone;
          end else if (data_start_q == HdrLen16) begin
            phase_d = PhPixel;
          end else begin
            phase_d = PhGap;
          end
        end
      end
      PhGap, PhPixel: begin
        if (pix_phase) begin
          phase_d = PhPixel;
          if (in_active) begin
            unique case (ch_q)
              2'd0:    hold_d = {16'd0, data_byte_i};
              2'd1:    hold_d[15:8]  = data_byte_i;
              2'd2:    hold_d[23:16] = data_byte_i;
              default: hold_d = hold_q;
            endcase
            ch_d = last_ch ? 2'd0 : ch_q + 2'd1;
            if (last_ch) col_d = col_inc[15:0];
          end
          // end of stored row, padding included
          if (lbc_inc >= {1'b0, stride_q}) begin
            lbc_d = '0;
            ch_d  = '0;
            col_d = '0;
            row_d = row_inc[15:0];
            if (row_inc >= {1'b0, height_q}) phase_d = PhDone;
          end else begin
            lbc_d = lbc_inc[17:0];
          end
        end
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_kind   = KindStatus;
    res_status = hdr_status;
    res_x      = '0;
    res_y      = '0;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_alpha  = '0;
    res_last   = 1'b0;
    if (pix_emit) begin
      res_kind   = KindPixel;
      res_status = StOk;
      res_x      = col_q;
      res_y      = height_q - 16'd1 - row_q;
      res_red    = four_ch ? hold_q[23:16] : data_byte_i;
      res_green  = hold_q[15:8];
      res_blue   = hold_q[7:0];
      res_alpha  = four_ch ? data_byte_i : AlphaOpaque;
      res_last   = (row_inc == {1'b0, height_q}) && (col_inc == {1'b0, width_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= PhHeader;
      data_start_q <= '0;
      width_q      <= '0;
      height_q     <= '0;
      depth_q      <= '0;
      marker_q     <= 1'b0;
      lbc_q        <= '0;
      ch_q         <= '0;
      col_q        <= '0;
      row_q        <= '0;
      hold_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_q        <= pos_d;
        phase_q      <= phase_d;
        data_start_q <= data_start_d;
        width_q      <= width_d;
        height_q     <= height_d;
        depth_q      <= depth_d;
        marker_q     <= marker_d;
        lbc_q        <= lbc_d;
        ch_q         <= ch_d;
        col_q        <= col_d;
        row_q        <= row_d;
        hold_q       <= hold_d;
      end
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q   <= res_kind;
      status_q <= res_status;
      img_w_q  <= width_q;
      img_h_q  <= height_q;
      pix_x_q  <= res_x;
      pix_y_q  <= res_y;
      red_q    <= res_red;
      green_q  <= res_green;
      blue_q   <= res_blue;
      alpha_q  <= res_alpha;
      last_q   <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign image_width_o  = img_w_q;
  assign image_height_o = img_h_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign alpha_o        = alpha_q;
  assign last_pixel_o   = last_q;

  // Checks
  `BMPR_ASSERT_NOW(a_no_overwrite, in_fire && out_valid_q && !out_ready_i, !emit, "stalled result overwritten")
  `BMPR_ASSERT_NEXT(a_done_sticky, in_fire && (phase_q == PhDone) && !first_byte_i, phase_q == PhDone, "left done without restart")
  `BMPR_ASSERT_NOW(a_pix_nonempty, pix_emit, (width_q != '0) && (height_q != '0), "pixel from empty image")
  `BMPR_ASSERT_NOW(a_lbc_in_row, phase_q == PhPixel, lbc_q < stride_q, "row byte count past stride")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for bmp_to_rgba_decoder_top.
// Streams BMP files one byte per request into the decoder. A behavioral
// decoder inside this module runs on every accepted byte. Each status or
// pixel result it produces is queued, and each result the block delivers
// is compared field by field against the oldest queued entry.
// The file length register is rewritten only between files, once the byte
// stream has drained and every queued result has been delivered.
module tb_top;
  import bmprgba_pkg::*;

  localparam int unsigned QuietLimit = 2000;  // cycles without any request or result taken

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } file_byte_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } decoded_t;

  // Ways a random file is damaged.
  typedef enum int {
    NzNone, NzMarker, NzDepth, NzLength, NzOffset, NzEmpty, NzCut, NzGarbage, NzAnyLen
  } noise_e;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        res_kind;
  logic [2:0]  res_status;
  logic [15:0] res_width, res_height, res_x, res_y;
  logic [7:0]  res_red, res_green, res_blue, res_alpha;
  logic        res_last;

  file_byte_t file_bytes_q[$];  // bytes waiting to be requested
  decoded_t   decoded_q[$];     // results the block still owes
  int         pushed = 0;       // bytes ever queued
  int         fails = 0;
  int         quiet = 0;
  bit         in_taken = 1'b0;  // request accepted at the last rising edge
  bit         calm = 1'b0;      // no idling on either side while set

  // Behavioral decoder state
  logic [31:0] cfg_len;
  logic [31:0] byte_pos;
  phase_e      dec_phase;
  logic [15:0] pix_offset, img_w, img_h;
  logic        four_ch;
  logic [17:0] row_stride;
  int unsigned row_bytes, col_cnt, row_cnt;
  logic [23:0] bgr_hold;
  logic        marker_ok;
  logic [7:0]  depth_val;

  bmp_to_rgba_decoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .first_byte_i   (first_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (res_kind),
    .status_o       (res_status),
    .image_width_o  (res_width),
    .image_height_o (res_height),
    .pixel_x_o      (res_x),
    .pixel_y_o      (res_y),
    .red_o          (res_red),
    .green_o        (res_green),
    .blue_o         (res_blue),
    .alpha_o        (res_alpha),
    .last_pixel_o   (res_last)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------
  task automatic restart_file();
    byte_pos   = '0;
    dec_phase  = PhHeader;
    pix_offset = '0;
    img_w      = '0;
    img_h      = '0;
    four_ch    = 1'b0;
    row_stride = '0;
    row_bytes  = 0;
    col_cnt    = 0;
    row_cnt    = 0;
    bgr_hold   = '0;
    marker_ok  = 1'b0;
    depth_val  = '0;
  endtask

  task automatic decode_file_byte(input logic [7:0] b, input logic first);
    decoded_t    r;
    status_e     st;
    logic [63:0] strd, need;
    int unsigned bpp, active, ch;
    r = '0;
    if (first) restart_file();
    if (dec_phase == PhHeader) begin
      case (byte_pos)
        PosMarkB: marker_ok = (b == MarkB);
        PosMarkM: marker_ok = marker_ok && (b == MarkM);
        PosOffLo: pix_offset[7:0] = b;
        PosOffHi: pix_offset[15:8] = b;
        PosWidLo: img_w[7:0] = b;
        PosWidHi: img_w[15:8] = b;
        PosHgtLo: img_h[7:0] = b;
        PosHgtHi: img_h[15:8] = b;
        PosDepth: depth_val = b;
        default: ;
      endcase
      if (byte_pos == 32'(PosHdrEnd)) begin
        // status priority: short, marker, depth, size (no wrap), offset
        if (cfg_len < HdrLen32) st = StShort;
        else if (!marker_ok) st = StNoMarker;
        else if (depth_val != Depth24 && depth_val != Depth32) st = StBadDepth;
        else begin
          bpp        = (depth_val == Depth32) ? 4 : 3;
          strd       = (64'(img_w) * bpp + 64'd3) & ~64'd3;
          row_stride = strd[17:0];
          four_ch    = (bpp == 4);
          need       = strd * 64'(img_h) + 64'(pix_offset);
          if (64'(cfg_len) < need) st = StTruncated;
          else if (pix_offset < HdrLen16) st = StOffsetInHeader;
          else st = StOk;
        end
        r.kind   = KindStatus;
        r.status = st;
        r.width  = img_w;
        r.height = img_h;
        decoded_q.push_back(r);
        if (st != StOk || img_w == '0 || img_h == '0) dec_phase = PhDone;
        else if (pix_offset == HdrLen16) dec_phase = PhPixel;
        else dec_phase = PhGap;
      end
    end else begin
      if (dec_phase == PhGap && byte_pos >= 32'(pix_offset)) dec_phase = PhPixel;
      if (dec_phase == PhPixel) begin
        bpp    = four_ch ? 4 : 3;
        active = 32'(img_w) * bpp;
        if (row_bytes < active) begin
          ch = row_bytes % bpp;
          if (ch == 0) bgr_hold = {16'd0, b};
          else if (ch < 3) bgr_hold[8*ch +: 8] = b;
          if (ch == bpp - 1) begin
            r.kind   = KindPixel;
            r.status = StOk;
            r.width  = img_w;
            r.height = img_h;
            r.px     = col_cnt[15:0];
            r.py     = img_h - 16'd1 - row_cnt[15:0];  // bottom row comes first
            r.red    = bgr_hold[23:16];
            r.green  = bgr_hold[15:8];
            r.blue   = bgr_hold[7:0];
            r.alpha  = four_ch ? b : AlphaOpaque;
            r.last   = (row_cnt + 1 == 32'(img_h)) && (col_cnt + 1 == 32'(img_w));
            col_cnt  = (col_cnt + 1) & 32'hFFFF;
            decoded_q.push_back(r);
          end
        end
        row_bytes++;
        if (row_bytes >= 32'(row_stride)) begin  // padding done, next row
          row_bytes = 0;
          col_cnt   = 0;
          row_cnt++;
          if (row_cnt >= 32'(img_h)) dec_phase = PhDone;
        end
      end
    end
    if (byte_pos != '1) byte_pos++;
  endtask

  // ---------------------------------------------------------------------
  // File builders
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] v, input logic first);
    file_byte_t fb;
    fb.data  = v;
    fb.first = first;
    file_bytes_q.push_back(fb);
    pushed++;
  endtask

  // random bytes, first one optionally flagged as a new file
  task automatic push_noise(input int n, input logic first);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), first && (i == 0));
  endtask

  function automatic longint pix_bytes(input logic [7:0] dep, input logic [15:0] w, h);
    longint strd;
    strd = (longint'(w) * ((dep == Depth32) ? 4 : 3) + 3) & ~longint'(3);
    return strd * longint'(h);
  endfunction

  // gap after the header plus all pixel rows
  function automatic int full_body(input logic [7:0] dep, input logic [15:0] off, w, h);
    return ((off > HdrLen16) ? int'(off - HdrLen16) : 0) + int'(pix_bytes(dep, w, h));
  endfunction

  task automatic queue_bmp(input logic [7:0] m0, m1, dep, input logic [15:0] off, w, h,
                           input int body, input logic first);
    logic [7:0] hdr [54];
    for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    hdr[PosMarkB] = m0;
    hdr[PosMarkM] = m1;
    hdr[PosOffLo] = off[7:0];
    hdr[PosOffHi] = off[15:8];
    hdr[PosWidLo] = w[7:0];
    hdr[PosWidHi] = w[15:8];
    hdr[PosHgtLo] = h[7:0];
    hdr[PosHgtHi] = h[15:8];
    hdr[PosDepth] = dep;
    for (int i = 0; i < 54; i++) push_byte(hdr[i], first && (i == 0));
    push_noise(body, 1'b0);
  endtask

  // Waits until the stream is drained and every result is in, lets the
  // pipeline settle, then writes the file length.
  task automatic set_len(input logic [31:0] v);
    while (file_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cfg_len = v;
  endtask

  // ---------------------------------------------------------------------
  // Request driver: changes inputs at the falling edge only
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    file_byte_t fb;
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (file_bytes_q.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
        fb = file_bytes_q.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= fb.data;
        first_byte <= fb.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  task automatic check_field(input string fld, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", fld, want, got);
      fails++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: input requests feed the decoder model first, then results are
  // checked, so a same-edge push can never be mistaken for a missing entry.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    decoded_t want;
    bit       took;
    if (rst_n) begin
      took = 1'b0;
      if (in_valid && in_ready) begin
        decode_file_byte(data_byte, first_byte);
        in_taken = 1'b1;
        took = 1'b1;
      end
      if (out_valid && out_ready) begin
        took = 1'b1;
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d", res_kind, res_status);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(res_kind));
          check_field("status", 16'(want.status), 16'(res_status));
          check_field("image_width", want.width, res_width);
          check_field("image_height", want.height, res_height);
          check_field("pixel_x", want.px, res_x);
          check_field("pixel_y", want.py, res_y);
          check_field("red", 16'(want.red), 16'(res_red));
          check_field("green", 16'(want.green), 16'(res_green));
          check_field("blue", 16'(want.blue), 16'(res_blue));
          check_field("alpha", 16'(want.alpha), 16'(res_alpha));
          check_field("last_pixel", 16'(want.last), 16'(res_last));
        end
      end
      quiet = took ? 0 : quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  m0, dep;
    logic [15:0] off, w, h;
    longint      need;
    logic [31:0] flen;
    int          extra, nf, start;
    noise_e      nz;

    cfg_len = '0;
    restart_file();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // --- directed files ---
    set_len('1);
    // byte zero right after reset without the new-file flag; odd width
    // for row padding; trailing bytes past the image are ignored
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'd3, 16'd2,
              full_body(Depth24, HdrLen16, 16'd3, 16'd2) + 5, 1'b0);
    // 32-bit with a gap between header and pixels
    queue_bmp(MarkB, MarkM, Depth32, 16'd60, 16'd2, 16'd2,
              full_body(Depth32, 16'd60, 16'd2, 16'd2), 1'b1);
    // restart in the middle of the pixels, then in the middle of a header
    queue_bmp(MarkB, MarkM, Depth32, HdrLen16, 16'd4, 16'd3, 20, 1'b1);
    push_noise(20, 1'b1);
    // marker errors
    queue_bmp(MarkM, MarkM, Depth24, HdrLen16, 16'd1, 16'd1, 4, 1'b1);
    queue_bmp(MarkB, MarkB, Depth24, HdrLen16, 16'd1, 16'd1, 4, 1'b1);
    // depth errors
    queue_bmp(MarkB, MarkM, 8'd16, HdrLen16, 16'd1, 16'd1, 4, 1'b1);
    queue_bmp(MarkB, MarkM, 8'd0, HdrLen16, 16'd1, 16'd1, 4, 1'b1);
    queue_bmp(MarkB, MarkM, 8'd255, HdrLen16, 16'd1, 16'd1, 4, 1'b1);
    // pixel offset pointing inside the header
    queue_bmp(MarkB, MarkM, Depth24, 16'd0, 16'd2, 16'd2, 8, 1'b1);
    queue_bmp(MarkB, MarkM, Depth32, 16'd53, 16'd2, 16'd2, 8, 1'b1);
    // empty images: ok status, rest of file ignored
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'd0, 16'd3, 12, 1'b1);
    queue_bmp(MarkB, MarkM, Depth32, HdrLen16, 16'd3, 16'd0, 12, 1'b1);
    // largest size cannot fit even in the largest file
    queue_bmp(MarkB, MarkM, Depth32, HdrLen16, 16'hFFFF, 16'hFFFF, 6, 1'b1);
    // widest and tallest images, streamed only partly
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'hFFFF, 16'd2, 60, 1'b1);
    queue_bmp(MarkB, MarkM, Depth32, HdrLen16, 16'd1, 16'hFFFF, 40, 1'b1);

    // file length below a header: status only if byte 53 arrives
    set_len('0);
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'd1, 16'd1, 4, 1'b1);
    push_noise(30, 1'b1);
    set_len(32'd53);
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'd1, 16'd1, 4, 1'b1);

    // size check must not wrap at 32 bits
    set_len(32'd1000000);
    queue_bmp(MarkB, MarkM, Depth32, HdrLen16, 16'hFFFF, 16'd16385, 8, 1'b1);

    // exact fit vs one byte short (5 pixels x 3 bytes, padded to 16)
    set_len(32'd102);
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'd5, 16'd3,
              full_body(Depth24, HdrLen16, 16'd5, 16'd3), 1'b1);
    set_len(32'd101);
    queue_bmp(MarkB, MarkM, Depth24, HdrLen16, 16'd5, 16'd3,
              full_body(Depth24, HdrLen16, 16'd5, 16'd3), 1'b1);

    // pixel offset well past the header, one pixel after the long gap
    set_len(32'd154);
    queue_bmp(MarkB, MarkM, Depth24, 16'd150, 16'd1, 16'd1,
              full_body(Depth24, 16'd150, 16'd1, 16'd1), 1'b1);

    // --- random files, mostly well formed ---
    start = pushed;
    while (pushed - start < 750) begin
      calm  = (pushed - start >= 250) && (pushed - start < 450);
      m0    = MarkB;
      dep   = $urandom_range(0, 1) ? Depth32 : Depth24;
      w     = 16'($urandom_range(1, 4));
      h     = 16'($urandom_range(1, 3));
      off   = ($urandom_range(0, 2) == 0) ? HdrLen16 + 16'($urandom_range(1, 8)) : HdrLen16;
      extra = $urandom_range(0, 3);
      need  = pix_bytes(dep, w, h) + longint'(off);
      flen  = ($urandom_range(0, 3) == 0) ? '1 : 32'(need) + 32'($urandom_range(0, 3));
      nf    = $urandom_range(1, 2);
      nz    = ($urandom_range(0, 99) < 25) ? noise_e'($urandom_range(1, 8)) : NzNone;
      case (nz)
        NzMarker: m0 = 8'($urandom);
        NzDepth:  dep = 8'($urandom);
        NzLength: flen = 32'(need) - 32'($urandom_range(1, int'(need)));
        NzOffset: off = 16'($urandom_range(0, 53));
        NzEmpty: begin
          if ($urandom_range(0, 1)) w = '0;
          else h = '0;
        end
        NzCut:    extra = -$urandom_range(1, full_body(dep, off, w, h));
        NzAnyLen: flen = $urandom;
        default: ;
      endcase
      set_len(flen);
      repeat (nf) begin
        if (nz == NzGarbage) push_noise(54 + $urandom_range(0, 10), 1'b1);
        else queue_bmp(m0, MarkM, dep, off, w, h, full_body(dep, off, w, h) + extra, 1'b1);
      end
    end
    calm = 1'b0;

    // drain, then give the pipeline time to show any stray result
    while (file_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/bmprgba_pkg.sv
src/bmp_to_rgba_decoder_top.sv
tb/tb_top.sv
